### design/lztd_pkg.sv
package lztd_pkg;

    localparam int WINDOW_SIZE = 32768;
    localparam int ADDR_W      = $clog2(WINDOW_SIZE);
    localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);
    localparam int DIST_W      = 16;
    localparam int CMP_W       = DIST_W + 1;
    localparam int LEN_CODE_W  = 8;
    localparam int LEN_W       = LEN_CODE_W + 1;
    localparam int MATCH_BASE  = 3;
    localparam int LANES       = 8;
    localparam int LANE_W      = $clog2(LANES);
    localparam int CNT_W       = 4;
    localparam int IN_DATA_W   = 8 + LEN_CODE_W + DIST_W;
    localparam int OUT_RAW_W   = LANES * 8 + CNT_W;
    localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_RAW_W;

    // one byte moving from the copy engine to the lane packer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_byte_xfer;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_eng_state;

endpackage

### design/lztd_engine.sv
module lztd_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_tok_valid,
    output logic                             o_tok_ready,
    input  logic                             i_is_match,
    input  logic [7:0]                       i_literal,
    input  logic [lztd_pkg::LEN_CODE_W-1:0]  i_length_code,
    input  logic [lztd_pkg::DIST_W-1:0]      i_distance,
    output lztd_pkg::t_byte_xfer             o_byte,
    input  logic                             i_byte_ready
);

    lztd_pkg::t_eng_state r_state;

    logic [7:0]                     r_hist [lztd_pkg::WINDOW_SIZE];
    logic [lztd_pkg::ADDR_W-1:0]    r_wp;
    logic [lztd_pkg::FILL_W-1:0]    r_filled;
    logic [lztd_pkg::ADDR_W-1:0]    r_src;
    logic [lztd_pkg::LEN_W-1:0]     r_rem;
    logic                           r_first;
    logic                           r_bad;
    logic                           r_lit_mode;
    logic [7:0]                     r_lit;
    logic                           r_dist_one;

    // read data stage
    logic                           r_v1;
    logic [7:0]                     r_rdata;
    logic                           r_fwd1;
    logic                           r_last1;
    logic [7:0]                     r_prev;

    logic                           accept;
    logic                           s1_adv;
    logic                           issue;
    logic [7:0]                     out_byte;
    logic [lztd_pkg::CMP_W-1:0]     dist_ext;
    logic [lztd_pkg::CMP_W-1:0]     wp_ext;
    logic                           n_bad;
    logic [lztd_pkg::CMP_W-1:0]     src_wide;
    logic [lztd_pkg::LEN_W-1:0]     n_total;

    assign o_tok_ready = (r_state == lztd_pkg::ST_IDLE);
    assign accept      = i_tok_valid && o_tok_ready;
    assign s1_adv      = r_v1 && i_byte_ready;
    assign issue       = (r_state == lztd_pkg::ST_ISSUE) && (!r_v1 || s1_adv);

    assign dist_ext = lztd_pkg::CMP_W'(i_distance);
    assign wp_ext   = lztd_pkg::CMP_W'(r_wp);
    assign n_bad    = (i_distance == '0)
                   || (dist_ext > lztd_pkg::CMP_W'(lztd_pkg::WINDOW_SIZE))
                   || (dist_ext > lztd_pkg::CMP_W'(r_filled));
    // wrap the backward source position into the window
    assign src_wide = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                    : (wp_ext + lztd_pkg::CMP_W'(lztd_pkg::WINDOW_SIZE) - dist_ext);
    assign n_total  = i_is_match
                    ? (lztd_pkg::LEN_W'(i_length_code) + lztd_pkg::LEN_W'(lztd_pkg::MATCH_BASE))
                    : lztd_pkg::LEN_W'(1);

    always_comb begin
        if (r_lit_mode) begin
            out_byte = r_lit;
        end else if (r_bad) begin
            out_byte = 8'h00;
        end else if (r_fwd1) begin
            out_byte = r_prev;
        end else begin
            out_byte = r_rdata;
        end
    end

    assign o_byte.valid = r_v1;
    assign o_byte.data  = out_byte;
    assign o_byte.last  = r_last1;
    assign o_byte.bad   = r_bad && !r_lit_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lztd_pkg::ST_IDLE;
            r_wp     <= '0;
            r_filled <= '0;
            r_v1     <= 1'b0;
        end else begin
            case (r_state)
                lztd_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_state <= lztd_pkg::ST_ISSUE;
                    end
                end
                lztd_pkg::ST_ISSUE: begin
                    if (issue && r_rem == lztd_pkg::LEN_W'(1)) begin
                        r_state <= lztd_pkg::ST_DRAIN;
                    end
                end
                lztd_pkg::ST_DRAIN: begin
                    if (s1_adv) begin
                        r_state <= lztd_pkg::ST_IDLE;
                    end
                end
                default: r_state <= lztd_pkg::ST_IDLE;
            endcase

            if (issue) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end

            if (s1_adv) begin
                r_wp <= (r_wp == lztd_pkg::ADDR_W'(lztd_pkg::WINDOW_SIZE - 1))
                      ? '0 : r_wp + 1'b1;
                if (r_filled != lztd_pkg::FILL_W'(lztd_pkg::WINDOW_SIZE)) begin
                    r_filled <= r_filled + 1'b1;
                end
            end
        end
    end

    // token payload and copy position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src      <= src_wide[lztd_pkg::ADDR_W-1:0];
            r_rem      <= n_total;
            r_first    <= 1'b1;
            r_bad      <= i_is_match && n_bad;
            r_lit_mode <= !i_is_match;
            r_lit      <= i_literal;
            r_dist_one <= i_is_match && (i_distance == lztd_pkg::DIST_W'(1));
        end else if (issue) begin
            r_src   <= (r_src == lztd_pkg::ADDR_W'(lztd_pkg::WINDOW_SIZE - 1))
                     ? '0 : r_src + 1'b1;
            r_rem   <= r_rem - 1'b1;
            r_first <= 1'b0;
        end
        if (issue) begin
            // distance one reads the byte written at this same edge: take it from r_prev
            r_fwd1  <= r_dist_one && !r_first;
            r_last1 <= (r_rem == lztd_pkg::LEN_W'(1));
        end
        if (s1_adv) begin
            r_prev <= out_byte;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_hist[r_wp] <= out_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_hist[r_src];
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lztd_pkg::ST_IDLE) |-> !r_v1)
        else $error("read stage holds a byte while idle");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= lztd_pkg::FILL_W'(lztd_pkg::WINDOW_SIZE))
        else $error("fill count beyond window");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lztd_pkg::ST_DRAIN) |-> (r_v1 && r_last1))
        else $error("drain without final byte pending");

endmodule

### design/lztd_packer.sv
module lztd_packer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lztd_pkg::t_byte_xfer                i_byte,
    output logic                                o_byte_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [lztd_pkg::LANES*8-1:0]        o_bytes,
    output logic [lztd_pkg::CNT_W-1:0]          o_count,
    output logic                                o_last,
    output logic                                o_bad
);

    logic [7:0]                   r_acc [lztd_pkg::LANES];
    logic [lztd_pkg::LANE_W-1:0]  r_cnt;
    logic                         r_ovalid;
    logic [lztd_pkg::LANES*8-1:0] r_out_bytes;
    logic [lztd_pkg::CNT_W-1:0]   r_out_cnt;
    logic                         r_out_last;
    logic                         r_out_bad;

    logic                         complete;
    logic                         take;
    logic [lztd_pkg::CNT_W-1:0]   n_cnt;
    logic [lztd_pkg::LANES*8-1:0] n_group;

    assign complete     = i_byte.last || (r_cnt == lztd_pkg::LANE_W'(lztd_pkg::LANES - 1));
    assign o_byte_ready = !complete || !r_ovalid || i_ready;
    assign take         = i_byte.valid && o_byte_ready;
    assign n_cnt        = lztd_pkg::CNT_W'(r_cnt) + 1'b1;

    // lanes above the new byte read as zero
    always_comb begin
        for (int k = 0; k < lztd_pkg::LANES; k++) begin
            if (lztd_pkg::LANE_W'(k) == r_cnt) begin
                n_group[k*8 +: 8] = i_byte.data;
            end else if (lztd_pkg::LANE_W'(k) < r_cnt) begin
                n_group[k*8 +: 8] = r_acc[k];
            end else begin
                n_group[k*8 +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (take) begin
                if (complete) begin
                    r_ovalid <= 1'b1;
                    r_cnt    <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (complete) begin
                r_out_bytes <= n_group;
                r_out_cnt   <= n_cnt;
                r_out_last  <= i_byte.last;
                r_out_bad   <= i_byte.bad;
            end else begin
                r_acc[r_cnt] <= i_byte.data;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_bytes = r_out_bytes;
    assign o_count = r_out_cnt;
    assign o_last  = r_out_last;
    assign o_bad   = r_out_bad;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out_cnt != '0
                      && r_out_cnt <= lztd_pkg::CNT_W'(lztd_pkg::LANES)))
        else $error("group count out of range");

    a_hold_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid)
        else $error("stalled group dropped");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_byte.last) |=> (r_cnt == '0))
        else $error("lane count not restarted after final byte");

endmodule

### design/lz77_token_decoder.sv
// Channel  Dir  Signals                     Contents (lowest bit first)
// s        in   i_s_tvalid/o_s_tready       tdata: literal[7:0], length_code[7:0],
//                                           distance[15:0]; tuser: is_match
// m        out  o_m_tvalid/i_m_tready       tdata: byte0..byte7, byte_count[3:0], pad;
//                                           tlast: last; tuser: bad_distance
//
// A token of L bytes (L = 1 for a literal, up to 258 for a match) holds the input from
// its transfer until its last byte has reached the packer; the bytes pass one per cycle
// while the output does not stall, through the single read port of the history memory,
// and the token's final group is registered in the packer when its last byte is taken.
// Reset clears the write pointer, fill count and control; history contents stay
// undefined and are never used before being written.
// A stall on the output holds the copy pipeline; the next token is taken once
// every byte of the current one has reached the packer.
module lz77_token_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lztd_pkg::IN_DATA_W-1:0]    i_s_tdata,  // literal, length_code, distance
    input  logic                              i_s_tuser,  // is_match
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [lztd_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // byte0..byte7, byte_count, pad
    output logic                              o_m_tlast,  // last
    output logic                              o_m_tuser   // bad_distance
);

    lztd_pkg::t_byte_xfer              byte_xfer;
    logic                              byte_ready;
    logic [lztd_pkg::LANES*8-1:0]      grp_bytes;
    logic [lztd_pkg::CNT_W-1:0]        grp_count;

    lztd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (i_s_tvalid),
        .o_tok_ready   (o_s_tready),
        .i_is_match    (i_s_tuser),
        .i_literal     (i_s_tdata[7:0]),
        .i_length_code (i_s_tdata[15:8]),
        .i_distance    (i_s_tdata[31:16]),
        .o_byte        (byte_xfer),
        .i_byte_ready  (byte_ready)
    );

    lztd_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_xfer),
        .o_byte_ready (byte_ready),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_bytes      (grp_bytes),
        .o_count      (grp_count),
        .o_last       (o_m_tlast),
        .o_bad        (o_m_tuser)
    );

    assign o_m_tdata = {{lztd_pkg::OUT_PAD_W{1'b0}}, grp_count, grp_bytes};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_FILL     = 140;
    localparam int NUM_RANDOM   = 200;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic                            is_match;
        logic [7:0]                      lit;
        logic [lztd_pkg::LEN_CODE_W-1:0] len_code;
        logic [lztd_pkg::DIST_W-1:0]     distance;
    } t_lz_token;

    typedef struct packed {
        logic [lztd_pkg::LANES-1:0][7:0] lanes;
        logic [lztd_pkg::CNT_W-1:0]      count;
        logic                            last;
        logic                            bad;
    } t_out_group;

    // want_cnt of zero leaves the row to the predictor
    typedef struct {
        logic       is_match;
        logic [7:0] lit;
        logic [7:0] len_code;
        int         distance;
        bit         from_fill;
        int         want_cnt;
        logic [7:0] want_b0;
        logic       want_bad;
    } t_dir_row;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lztd_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lztd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;

    // predictor state
    logic [7:0]                  hist_mem [lztd_pkg::WINDOW_SIZE];
    logic [lztd_pkg::ADDR_W-1:0] wr_ptr        = '0;
    logic [lztd_pkg::FILL_W-1:0] bytes_written = '0;
    t_out_group                  pending_groups [$];

    int mismatch_count = 0;
    bit calm           = 1'b0;

    lz77_token_decoder i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // literal, length_code, distance
        .i_s_tuser  (s_tuser),   // is_match
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // byte0..byte7, byte_count, pad
        .o_m_tlast  (m_tlast),   // last
        .o_m_tuser  (m_tuser)    // bad_distance
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // switch between stretches with and without idling
    initial begin
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        if (bytes_written < lztd_pkg::WINDOW_SIZE) bytes_written = bytes_written + 1'b1;
    endfunction

    function automatic void decode_token(t_lz_token tok);
        t_out_group                  grp;
        int                          total;
        int                          done;
        int                          n;
        logic                        bad;
        logic [7:0]                  b;
        logic [lztd_pkg::ADDR_W-1:0] src;
        if (!tok.is_match) begin
            grp = '0;
            grp.lanes[0] = tok.lit;
            grp.count = lztd_pkg::CNT_W'(1);
            grp.last = 1'b1;
            store_byte(tok.lit);
            pending_groups.push_back(grp);
            return;
        end
        total = int'(tok.len_code) + lztd_pkg::MATCH_BASE;
        bad = (tok.distance == 0) || (tok.distance > lztd_pkg::WINDOW_SIZE)
           || (tok.distance > bytes_written);
        done = 0;
        while (done < total) begin
            grp = '0;
            n = 0;
            // copy one byte at a time so an overlapping copy sees its own output
            while (n < lztd_pkg::LANES && done < total) begin
                src = wr_ptr - tok.distance[lztd_pkg::ADDR_W-1:0];
                b = bad ? 8'h00 : hist_mem[src];
                store_byte(b);
                grp.lanes[n] = b;
                n++;
                done++;
            end
            grp.count = lztd_pkg::CNT_W'(n);
            grp.last = (done == total);
            grp.bad = bad;
            pending_groups.push_back(grp);
        end
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatch_count < 40)
            $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_token(t_lz_token tok, int want_cnt, logic [7:0] want_b0,
                              logic want_bad);
        int         gap;
        t_out_group grp;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= tok.is_match;
        s_tdata  <= {tok.distance, tok.len_code, tok.lit};
        do @(posedge clk); while (!s_tready);
        decode_token(tok);
        if (want_cnt > 0) begin
            grp = '0;
            grp.lanes[0] = want_b0;
            grp.count = lztd_pkg::CNT_W'(want_cnt);
            grp.last = 1'b1;
            grp.bad = want_bad;
            pending_groups[pending_groups.size() - 1] = grp;
        end
    endtask

    initial begin : out_stall
        int hold;
        hold = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk) begin : check_out
        t_out_group want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_groups.size() == 0) begin
                flag_mismatch("group with nothing pending, byte_count",
                              m_tdata[lztd_pkg::LANES*8 +: lztd_pkg::CNT_W], 0);
            end else begin
                want = pending_groups.pop_front();
                for (int k = 0; k < lztd_pkg::LANES; k++)
                    if (m_tdata[8*k +: 8] !== want.lanes[k])
                        flag_mismatch($sformatf("byte%0d", k), m_tdata[8*k +: 8],
                                      want.lanes[k]);
                if (m_tdata[lztd_pkg::LANES*8 +: lztd_pkg::CNT_W] !== want.count)
                    flag_mismatch("byte_count",
                                  m_tdata[lztd_pkg::LANES*8 +: lztd_pkg::CNT_W], want.count);
                if (m_tlast !== want.last)
                    flag_mismatch("last", m_tlast, want.last);
                if (m_tuser !== want.bad)
                    flag_mismatch("bad_distance", m_tuser, want.bad);
            end
        end
    end

    initial begin : stimulus
        t_lz_token tok;
        t_dir_row  rows [NUM_DIRECTED];
        int        r;

        // is_match, literal, length_code, distance, from_fill, count, byte0, bad
        rows[0]  = '{1'b1, 8'h00, 8'h00, 1,       1'b0, 3, 8'h00, 1'b1}; // nothing written yet
        rows[1]  = '{1'b0, 8'h00, 8'h00, 0,       1'b0, 1, 8'h00, 1'b0};
        rows[2]  = '{1'b0, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 1, 8'hFF, 1'b0};
        rows[3]  = '{1'b0, 8'hA5, 8'h5A, 0,       1'b0, 1, 8'hA5, 1'b0};
        rows[4]  = '{1'b0, 8'h5A, 8'h00, 16'h8000, 1'b0, 1, 8'h5A, 1'b0};
        rows[5]  = '{1'b1, 8'h00, 8'h00, 1,       1'b0, 0, 8'h00, 1'b0}; // repeat last byte
        rows[6]  = '{1'b1, 8'hFF, 8'h05, 2,       1'b0, 0, 8'h00, 1'b0}; // exactly one group
        rows[7]  = '{1'b1, 8'h00, 8'h06, 3,       1'b0, 0, 8'h00, 1'b0}; // spills to a second
        rows[8]  = '{1'b1, 8'h00, 8'h00, 0,       1'b0, 3, 8'h00, 1'b1}; // zero distance
        rows[9]  = '{1'b1, 8'h00, 8'h00, 16'hFFFF, 1'b0, 3, 8'h00, 1'b1};
        rows[10] = '{1'b1, 8'h00, 8'h00, 16'h8001, 1'b0, 3, 8'h00, 1'b1};
        rows[11] = '{1'b1, 8'h00, 8'h00, 16'h8000, 1'b0, 3, 8'h00, 1'b1}; // window not full
        rows[12] = '{1'b1, 8'h00, 8'h00, 1,       1'b1, 3, 8'h00, 1'b1}; // one past filled
        rows[13] = '{1'b1, 8'h00, 8'hFF, 0,       1'b1, 0, 8'h00, 1'b0}; // oldest byte
        rows[14] = '{1'b1, 8'h00, 8'hFF, 1,       1'b0, 0, 8'h00, 1'b0};
        rows[15] = '{1'b1, 8'h00, 8'hFF, 0,       1'b0, 0, 8'h00, 1'b0}; // long bad copy
        rows[16] = '{1'b0, 8'h80, 8'h00, 0,       1'b0, 1, 8'h80, 1'b0};
        rows[17] = '{1'b1, 8'h33, 8'h04, 5,       1'b0, 0, 8'h00, 1'b0};
        rows[18] = '{1'b1, 8'h00, 8'hAA, 16'h0155, 1'b0, 0, 8'h00, 1'b0};
        rows[19] = '{1'b1, 8'h00, 8'h0F, 16'h02AA, 1'b0, 0, 8'h00, 1'b0};
        rows[20] = '{1'b0, 8'h7E, 8'h55, 16'h7FFF, 1'b0, 1, 8'h7E, 1'b0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            tok.is_match = rows[i].is_match;
            tok.lit      = rows[i].lit;
            tok.len_code = rows[i].len_code;
            tok.distance = lztd_pkg::DIST_W'(rows[i].from_fill
                                             ? int'(bytes_written) + rows[i].distance
                                             : rows[i].distance);
            send_token(tok, rows[i].want_cnt, rows[i].want_b0, rows[i].want_bad);
        end

        // fill the whole window with long copies so the pointer wraps
        repeat (NUM_FILL) begin
            tok.is_match = 1'b1;
            tok.lit      = 8'($urandom);
            tok.len_code = '1;
            tok.distance = lztd_pkg::DIST_W'($urandom_range(1, bytes_written));
            send_token(tok, 0, 8'h00, 1'b0);
        end

        repeat (NUM_RANDOM) begin
            r = $urandom_range(0, 99);
            tok.is_match = (r >= 22);
            tok.lit      = 8'($urandom);
            tok.len_code = 8'($urandom);
            tok.distance = lztd_pkg::DIST_W'($urandom);
            if (tok.is_match) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: tok.len_code = 8'($urandom_range(0, 12));
                    7, 8:                tok.len_code = 8'($urandom_range(13, 254));
                    default:             tok.len_code = '1;
                endcase
            end
            if (tok.is_match && r < 90) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                        tok.distance = lztd_pkg::DIST_W'($urandom_range(1,
                                       (bytes_written < 16) ? bytes_written : 16));
                    4, 5, 6, 7, 8:
                        tok.distance = lztd_pkg::DIST_W'($urandom_range(1, bytes_written));
                    default:
                        tok.distance = bytes_written;
                endcase
            end else if (tok.is_match) begin
                case ($urandom_range(0, 2))
                    0:       tok.distance = '0;
                    1:       tok.distance = bytes_written + 1'b1;
                    default: tok.distance = lztd_pkg::DIST_W'(
                                 $urandom_range(lztd_pkg::WINDOW_SIZE + 1, 65535));
                endcase
            end
            send_token(tok, 0, 8'h00, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (pending_groups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
